>>> design/crfdt_pkg.sv
// package: types, constants and codes of the rectangle fill engine
`default_nettype none

package crfdt_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int DIRTY_SLOTS = 16;

  localparam int PIX_AW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DIRTY_AW = 4;
  localparam int USED_W   = 5;
  localparam int DIM_W    = 9;
  localparam int COORD_W  = 8;
  localparam int POS_W    = 16;
  localparam int PIX_W    = 32;
  localparam int CMD_W    = 3;
  localparam int CFG_AW   = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_FILL       = 3'd0,
    CMD_SET        = 3'd1,
    CMD_READ_PIX   = 3'd2,
    CMD_READ_DIRTY = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_e;

  typedef enum logic [CFG_AW-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ACCESS,
    ST_FILL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [POS_W-1:0]    rect_width;
    logic [POS_W-1:0]    rect_height;
    logic [PIX_W-1:0]    colour;
    logic [DIRTY_AW-1:0] dirty_index;
  } in_t;

  typedef struct packed {
    logic               ok;
    logic [PIX_W-1:0]   pixel_value;
    logic [COORD_W-1:0] dirty_x;
    logic [COORD_W-1:0] dirty_y;
    logic [DIM_W-1:0]   dirty_w;
    logic [DIM_W-1:0]   dirty_h;
    logic [USED_W-1:0]  dirty_total;
  } out_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
  } dirty_ent_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [PIX_AW-1:0] addr;
    logic [PIX_W-1:0]  wdata;
  } pix_req_t;

  typedef struct packed {
    logic                we;
    logic                re;
    logic [DIRTY_AW-1:0] waddr;
    logic [DIRTY_AW-1:0] raddr;
    dirty_ent_t          wdata;
  } dirty_req_t;

endpackage

`default_nettype wire

>>> design/crfdt_if.sv
// valid/ready channel interfaces for commands and results
`default_nettype none

interface crfdt_in_if;
  import crfdt_pkg::*;

  logic valid;
  logic ready;
  in_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface crfdt_out_if;
  import crfdt_pkg::*;

  logic valid;
  logic ready;
  out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/clipped_rect_fill_dirty_tracker.sv
// top level: clipped rectangle fill engine with dirty rectangle list
//
//   channel   dir   handshake              contents
//   in_i      in    valid/ready            command, position, size, colour, index
//   out_o     out   valid/ready            ok, pixel, dirty entry, dirty count
//   cfg       in    cfg_we_i, no back-off  frame_width (0), frame_height (1)
//
// a fill writes the clipped rectangle, one pixel write per cycle through the
// single frame store port; other commands go from decode to done, set and pixel read via access
// no clearing pass after reset; the frame store and dirty list hold no reset
// a new transaction is taken while the previous result waits in the output
// register; a stalled output holds the next result in the sequencer
`default_nettype none

module clipped_rect_fill_dirty_tracker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [crfdt_pkg::CFG_AW-1:0]  cfg_index_i,
  input  wire logic [crfdt_pkg::DIM_W-1:0]   cfg_wdata_i,
  crfdt_in_if.sink                           in_i,
  crfdt_out_if.source                        out_o
);
  import crfdt_pkg::*;

  pix_req_t         pix_req;
  logic [PIX_W-1:0] pix_rdata;
  dirty_req_t       dirty_req;
  dirty_ent_t       dirty_rdata;

  crfdt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_i          (in_i),
    .out_o         (out_o),
    .pix_req_o     (pix_req),
    .pix_rdata_i   (pix_rdata),
    .dirty_req_o   (dirty_req),
    .dirty_rdata_i (dirty_rdata)
  );

  crfdt_frame_store u_frame (
    .clk_i   (clk_i),
    .req_i   (pix_req),
    .rdata_o (pix_rdata)
  );

  crfdt_dirty_store u_dirty (
    .clk_i   (clk_i),
    .req_i   (dirty_req),
    .rdata_o (dirty_rdata)
  );

endmodule

`default_nettype wire

>>> design/crfdt_frame_store.sv
// pixel store: single-port synchronous memory with a registered read
`default_nettype none

module crfdt_frame_store (
  input  wire logic                                  clk_i,
  input  wire crfdt_pkg::pix_req_t                   req_i,
  output logic [crfdt_pkg::PIX_W-1:0]                rdata_o
);
  import crfdt_pkg::*;

  logic [PIX_W-1:0] mem [MAX_WIDTH*MAX_HEIGHT];
  logic [PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/crfdt_dirty_store.sv
// dirty rectangle list: synchronous memory with one write and one read port
`default_nettype none

module crfdt_dirty_store (
  input  wire logic                  clk_i,
  input  wire crfdt_pkg::dirty_req_t req_i,
  output crfdt_pkg::dirty_ent_t      rdata_o
);
  import crfdt_pkg::*;

  dirty_ent_t mem [DIRTY_SLOTS];
  dirty_ent_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/crfdt_ctrl.sv
// command sequencer: decode, clipping, fill address walk, dirty count, result register
`default_nettype none

module crfdt_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [crfdt_pkg::CFG_AW-1:0]  cfg_index_i,
  input  wire logic [crfdt_pkg::DIM_W-1:0]   cfg_wdata_i,
  crfdt_in_if.sink                           in_i,
  crfdt_out_if.source                        out_o,
  output crfdt_pkg::pix_req_t                pix_req_o,
  input  wire logic [crfdt_pkg::PIX_W-1:0]   pix_rdata_i,
  output crfdt_pkg::dirty_req_t              dirty_req_o,
  input  wire crfdt_pkg::dirty_ent_t         dirty_rdata_i
);
  import crfdt_pkg::*;

  state_e state_q, state_d;

  logic [DIM_W-1:0]  frame_width_q, frame_height_q;
  in_t               item_q;
  logic              ok_q;
  logic [DIM_W-1:0]  cw_q, ch_q;
  logic [DIM_W-1:0]  col_q, row_q;
  logic [PIX_AW-1:0] addr_q, row_base_q;
  logic [USED_W-1:0] used_q;
  logic              out_valid_q;
  out_t              out_q;

  logic [DIM_W-1:0]   fw, fh;
  logic               in_frame, fill_ok, dirty_hit, has_room, ok_d;
  logic [POS_W:0]     x_end, y_end;
  logic [POS_W:0]     cw_full, ch_full;
  logic [DIM_W-1:0]   cw_d, ch_d;
  logic [COORD_W+DIM_W-1:0] base_full;
  logic               col_last, row_last, fill_last, out_load;
  out_t               out_d;

  // active frame size, clamped to the store dimensions
  assign fw = (frame_width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : frame_width_q;
  assign fh = (frame_height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : frame_height_q;

  assign in_frame = (item_q.pos_x < POS_W'(fw)) && (item_q.pos_y < POS_W'(fh));
  assign fill_ok  = in_frame && (item_q.rect_width != '0) && (item_q.rect_height != '0);

  // clip to the frame edge
  assign x_end   = {1'b0, item_q.pos_x} + {1'b0, item_q.rect_width};
  assign y_end   = {1'b0, item_q.pos_y} + {1'b0, item_q.rect_height};
  assign cw_full = (x_end > (POS_W+1)'(fw)) ? ((POS_W+1)'(fw) - {1'b0, item_q.pos_x})
                                              : {1'b0, item_q.rect_width};
  assign ch_full = (y_end > (POS_W+1)'(fh)) ? ((POS_W+1)'(fh) - {1'b0, item_q.pos_y})
                                              : {1'b0, item_q.rect_height};
  assign cw_d = cw_full[DIM_W-1:0];
  assign ch_d = ch_full[DIM_W-1:0];

  assign base_full = (COORD_W+DIM_W)'(item_q.pos_y[COORD_W-1:0]) * (COORD_W+DIM_W)'(fw)
                   + (COORD_W+DIM_W)'(item_q.pos_x[COORD_W-1:0]);

  assign dirty_hit = ({1'b0, item_q.dirty_index} < used_q);
  assign has_room  = (used_q < USED_W'(DIRTY_SLOTS));

  assign col_last  = (col_q == cw_q - DIM_W'(1));
  assign row_last  = (row_q == ch_q - DIM_W'(1));
  assign fill_last = col_last && row_last;

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    unique case (item_q.command)
      CMD_FILL:       ok_d = fill_ok;
      CMD_SET:        ok_d = in_frame;
      CMD_READ_PIX:   ok_d = in_frame;
      CMD_READ_DIRTY: ok_d = dirty_hit;
      CMD_CLEAR:      ok_d = 1'b1;
      default:        ok_d = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        priority if (item_q.command == CMD_FILL && fill_ok) begin
          state_d = ST_FILL;
        end else if ((item_q.command == CMD_SET || item_q.command == CMD_READ_PIX)
                     && in_frame) begin
          state_d = ST_ACCESS;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_ACCESS: state_d = ST_DONE;
      ST_FILL: begin
        if (fill_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_i.ready = (state_q == ST_IDLE);

    pix_req_o.we    = (state_q == ST_FILL) ||
                      (state_q == ST_ACCESS && item_q.command == CMD_SET);
    pix_req_o.re    = (state_q == ST_ACCESS && item_q.command == CMD_READ_PIX);
    pix_req_o.addr  = addr_q;
    pix_req_o.wdata = item_q.colour;

    dirty_req_o.we      = (state_q == ST_FILL) && fill_last && has_room;
    dirty_req_o.waddr   = used_q[DIRTY_AW-1:0];
    dirty_req_o.wdata.x = item_q.pos_x[COORD_W-1:0];
    dirty_req_o.wdata.y = item_q.pos_y[COORD_W-1:0];
    dirty_req_o.wdata.w = cw_q;
    dirty_req_o.wdata.h = ch_q;
    dirty_req_o.re      = (state_q == ST_DECODE) && (item_q.command == CMD_READ_DIRTY);
    dirty_req_o.raddr   = item_q.dirty_index;

    out_d.ok          = ok_q;
    out_d.pixel_value = (ok_q && item_q.command == CMD_READ_PIX) ? pix_rdata_i : '0;
    if (ok_q && item_q.command == CMD_READ_DIRTY) begin
      out_d.dirty_x = dirty_rdata_i.x;
      out_d.dirty_y = dirty_rdata_i.y;
      out_d.dirty_w = dirty_rdata_i.w;
      out_d.dirty_h = dirty_rdata_i.h;
    end else begin
      out_d.dirty_x = '0;
      out_d.dirty_y = '0;
      out_d.dirty_w = '0;
      out_d.dirty_h = '0;
    end
    out_d.dirty_total = used_q;

    out_o.valid   = out_valid_q;
    out_o.payload = out_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      frame_width_q  <= DIM_W'(256);
      frame_height_q <= DIM_W'(256);
      used_q         <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
          CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (state_q == ST_DECODE && item_q.command == CMD_CLEAR) begin
        used_q <= '0;
      end else if (dirty_req_o.we) begin
        used_q <= used_q + USED_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= in_i.payload;
    end
    if (out_load) begin
      out_q <= out_d;
    end
    unique case (state_q)
      ST_DECODE: begin
        ok_q       <= ok_d;
        cw_q       <= cw_d;
        ch_q       <= ch_d;
        col_q      <= '0;
        row_q      <= '0;
        addr_q     <= base_full[PIX_AW-1:0];
        row_base_q <= base_full[PIX_AW-1:0];
      end
      ST_FILL: begin
        if (col_last) begin
          col_q      <= '0;
          row_q      <= row_q + DIM_W'(1);
          row_base_q <= row_base_q + PIX_AW'(fw);
          addr_q     <= row_base_q + PIX_AW'(fw);
        end else begin
          col_q  <= col_q + DIM_W'(1);
          addr_q <= addr_q + PIX_AW'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
